// ===== hw/rtl/two_voice_wavetable_sequencer_core_macros.svh =====
// Assertion helpers for the sequencer core; clk and rst_n are taken from the using scope.
`ifndef TWO_VOICE_WAVETABLE_SEQUENCER_CORE_MACROS_SVH
`define TWO_VOICE_WAVETABLE_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define TVWS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TVWS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tvws_pkg.sv =====
package tvws_pkg;

    localparam int MAX_NOTES_DEF   = 128;
    localparam int WAVE_LENGTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int OPCODE_W = 3;
    localparam int EIDX_W   = 7;
    localparam int PERIOD_W = 24;
    localparam int NLEN_W   = 16;
    localparam int WIDX_W   = 6;
    localparam int WVAL_W   = 12;
    localparam int SAMPLE_W = 12;
    localparam int CNT_W    = 8;
    localparam int SEL_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [OPCODE_W-1:0] OP_BEAT      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_MEL_TICK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HAR_TICK  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LOAD_NOTE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LOAD_WAVE = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_RESTART   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SONG_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_S1_MELODY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_S1_HARMONY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_S2_MELODY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_S2_HARMONY  = 3'd4;

    localparam logic [SEL_W-1:0] SEL_SLOT1 = 2'd1;
    localparam logic [SEL_W-1:0] SEL_SLOT2 = 2'd2;

    localparam logic [CNT_W-1:0] S1_COUNT_RST = 8'd106;
    localparam logic [CNT_W-1:0] S2_COUNT_RST = 8'd8;

    // what the second stage does with a request
    typedef struct packed {
        logic zero_levels;
        logic wave_m;
        logic wave_h;
        logic per_m;
        logic per_h;
        logic ended;
    } tvws_ctrl_t;

endpackage

// ===== hw/rtl/tvws_mix.sv =====
module tvws_mix #(
    parameter int SAMPLE_BITS = tvws_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    input  tvws_pkg::tvws_ctrl_t          ctrl,
    input  logic [SAMPLE_BITS-1:0]        wave_q,
    input  logic [tvws_pkg::PERIOD_W-1:0] mel_period_q,
    input  logic [tvws_pkg::PERIOD_W-1:0] har_period_q,
    output logic                          s1_take,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          sample_valid,
    output logic [tvws_pkg::SAMPLE_W-1:0] sample,
    output logic                          melody_period_valid,
    output logic [tvws_pkg::PERIOD_W-1:0] melody_period,
    output logic                          harmony_period_valid,
    output logic [tvws_pkg::PERIOD_W-1:0] harmony_period,
    output logic                          song_ended
);
    import tvws_pkg::*;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] level_m_reg, level_m_next;
    logic [SAMPLE_BITS-1:0] level_h_reg, level_h_next;
    logic [SAMPLE_BITS:0]   level_sum;
    logic                   sv_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic                   mv_reg, hv_reg, ended_reg;
    logic [PERIOD_W-1:0]    mper_reg, hper_reg;

    assign s1_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        level_m_next = ctrl.wave_m ? wave_q : level_m_reg;
        level_h_next = ctrl.wave_h ? wave_q : level_h_reg;
        if (ctrl.zero_levels)
        begin
            level_m_next = '0;
            level_h_next = '0;
        end
        level_sum = {1'b0, level_m_next} + {1'b0, level_h_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            level_m_reg   <= '0;
            level_h_reg   <= '0;
        end
        else if (s1_valid && s1_take)
        begin
            out_valid_reg <= 1'b1;
            level_m_reg   <= level_m_next;
            level_h_reg   <= level_h_next;
        end
        else if (s1_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_take)
        begin
            sv_reg     <= ctrl.wave_m || ctrl.wave_h;
            sample_reg <= (ctrl.wave_m || ctrl.wave_h)
                          ? SAMPLE_W'(level_sum[SAMPLE_BITS:1]) : '0;
            mv_reg     <= ctrl.per_m;
            mper_reg   <= ctrl.per_m ? mel_period_q : '0;
            hv_reg     <= ctrl.per_h;
            hper_reg   <= ctrl.per_h ? har_period_q : '0;
            ended_reg  <= ctrl.ended;
        end
    end

    assign out_valid            = out_valid_reg;
    assign sample_valid         = sv_reg;
    assign sample               = sample_reg;
    assign melody_period_valid  = mv_reg;
    assign melody_period        = mper_reg;
    assign harmony_period_valid = hv_reg;
    assign harmony_period       = hper_reg;
    assign song_ended           = ended_reg;

endmodule

// ===== hw/rtl/two_voice_wavetable_sequencer_core.sv =====
// Two-voice wavetable note sequencer.
// Input channel (in_valid / in_stall) carries one request per item: beat tick,
// melody or harmony pitch tick, note load, wave load or restart. Every request
// gives exactly one result on the output channel (out_valid / out_stall).
// Configuration (song select, per-slot note counts) is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce; unknown indexes are dropped.
// Throughput: one request per clock while in_stall is low. Each result passes
// through the synchronous read of the note memory and wavetable in the second
// stage, then the output register. A note length read on one beat is forwarded
// straight to the next request's beat compare. When out_stall holds a result,
// one more request is taken into the second stage and in_stall then rises until
// the output moves. Reset clears positions, counters, levels, the ended flag and
// the configuration to its defaults; note memory and wavetable are not cleared
// and must be loaded before they are played.
`include "two_voice_wavetable_sequencer_core_macros.svh"

module two_voice_wavetable_sequencer_core #(
    parameter int MAX_NOTES   = tvws_pkg::MAX_NOTES_DEF,
    parameter int WAVE_LENGTH = tvws_pkg::WAVE_LENGTH_DEF,
    parameter int SAMPLE_BITS = tvws_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tvws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvws_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tvws_pkg::OPCODE_W-1:0]   opcode,
    input  logic                            song_slot,
    input  logic                            voice,
    input  logic [tvws_pkg::EIDX_W-1:0]     entry_index,
    input  logic [tvws_pkg::PERIOD_W-1:0]   pitch_period,
    input  logic [tvws_pkg::NLEN_W-1:0]     note_length,
    input  logic [tvws_pkg::WIDX_W-1:0]     wave_index,
    input  logic [tvws_pkg::WVAL_W-1:0]     wave_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            sample_valid,
    output logic [tvws_pkg::SAMPLE_W-1:0]   sample,
    output logic                            melody_period_valid,
    output logic [tvws_pkg::PERIOD_W-1:0]   melody_period,
    output logic                            harmony_period_valid,
    output logic [tvws_pkg::PERIOD_W-1:0]   harmony_period,
    output logic                            song_ended
);
    import tvws_pkg::*;

    localparam int POS_W  = $clog2(MAX_NOTES + 1);
    localparam int ADDR_W = $clog2(4 * MAX_NOTES);
    localparam int WP_W   = $clog2(WAVE_LENGTH);
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int WORD_W = PERIOD_W + NLEN_W;

    // configuration
    logic [SEL_W-1:0] sel_reg;
    logic [CNT_W-1:0] s1_mel_reg, s1_har_reg, s2_mel_reg, s2_har_reg;

    // sequencer state
    logic [POS_W-1:0]  mel_pos_reg, mel_pos_next, har_pos_reg, har_pos_next;
    logic [NLEN_W-1:0] mel_beat_reg, mel_beat_next, har_beat_reg, har_beat_next;
    logic [NLEN_W-1:0] mel_len_reg, har_len_reg;
    logic [WP_W-1:0]   mel_wave_reg, mel_wave_next, har_wave_reg, har_wave_next;
    logic              ended_reg, ended_next;

    // second stage
    logic       s1_valid_reg;
    tvws_ctrl_t ctrl_reg, ctrl_next;
    logic       s1_take;
    logic       accept;

    // memories
    logic [WORD_W-1:0]      note_mem [4*MAX_NOTES];
    logic [SAMPLE_BITS-1:0] wave_mem [WAVE_LENGTH];
    logic [WORD_W-1:0]      mel_q, har_q;
    logic [SAMPLE_BITS-1:0] wave_q;
    logic                   note_we, rd_m_en, rd_h_en, wave_we, wave_rd_en;
    logic [ADDR_W-1:0]      note_waddr, rd_m_addr, rd_h_addr;
    logic [WP_W-1:0]        wave_waddr, wave_raddr;

    logic              chosen, slot2;
    logic [CNT_W-1:0]  cnt_m, cnt_h;
    logic [POS_W-1:0]  lim_m, lim_h;
    logic [NLEN_W-1:0] len_m_eff, len_h_eff, mb_inc, hb_inc;

    function automatic logic [ADDR_W-1:0] note_addr(input logic s, input logic v,
                                                    input logic [ADDR_W-1:0] pos);
        note_addr = ADDR_W'(s ? 2 * MAX_NOTES : 0) + ADDR_W'(v ? MAX_NOTES : 0) + pos;
    endfunction

    function automatic logic [WP_W-1:0] wave_step(input logic [WP_W-1:0] p);
        wave_step = (p == WP_W'(WAVE_LENGTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !s1_take;

    assign chosen = (sel_reg == SEL_SLOT1) || (sel_reg == SEL_SLOT2);
    assign slot2  = (sel_reg == SEL_SLOT2);
    assign cnt_m  = slot2 ? s2_mel_reg : s1_mel_reg;
    assign cnt_h  = slot2 ? s2_har_reg : s1_har_reg;

    // song length per voice, clipped to the table depth
    always_comb
    begin
        lim_m = POS_W'(MAX_NOTES);
        lim_h = POS_W'(MAX_NOTES);
        if (chosen)
        begin
            if (CMP_W'(cnt_m) <= CMP_W'(MAX_NOTES))
                lim_m = POS_W'(CMP_W'(cnt_m));
            if (CMP_W'(cnt_h) <= CMP_W'(MAX_NOTES))
                lim_h = POS_W'(CMP_W'(cnt_h));
        end
    end

    // note length still in flight in the second stage is forwarded
    assign len_m_eff = (s1_valid_reg && ctrl_reg.per_m) ? mel_q[NLEN_W-1:0] : mel_len_reg;
    assign len_h_eff = (s1_valid_reg && ctrl_reg.per_h) ? har_q[NLEN_W-1:0] : har_len_reg;
    assign mb_inc = (mel_beat_reg == '1) ? mel_beat_reg : mel_beat_reg + 1'b1;
    assign hb_inc = (har_beat_reg == '1) ? har_beat_reg : har_beat_reg + 1'b1;

    always_comb
    begin
        mel_pos_next  = mel_pos_reg;
        har_pos_next  = har_pos_reg;
        mel_beat_next = mel_beat_reg;
        har_beat_next = har_beat_reg;
        mel_wave_next = mel_wave_reg;
        har_wave_next = har_wave_reg;
        ended_next    = ended_reg;
        ctrl_next     = '0;
        note_we       = 1'b0;
        note_waddr    = note_addr(song_slot, voice, ADDR_W'(entry_index));
        rd_m_en       = 1'b0;
        rd_h_en       = 1'b0;
        rd_m_addr     = note_addr(slot2, 1'b0, '0);
        rd_h_addr     = note_addr(slot2, 1'b1, '0);
        wave_we       = 1'b0;
        wave_waddr    = WP_W'(wave_index);
        wave_rd_en    = 1'b0;
        wave_raddr    = mel_wave_reg;
        case (opcode)
            OP_BEAT:
            begin
                mel_beat_next = mb_inc;
                har_beat_next = hb_inc;
                if (chosen && (mel_pos_reg >= lim_m || har_pos_reg >= lim_h))
                begin
                    ended_next = 1'b1;
                    ctrl_next.zero_levels = 1'b1;
                end
                if (mb_inc >= len_m_eff)
                begin
                    if (mel_pos_reg < lim_m)
                        mel_pos_next = mel_pos_reg + 1'b1;
                    mel_wave_next = '0;
                    mel_beat_next = '0;
                    if (chosen && mel_pos_next < lim_m)
                    begin
                        rd_m_en = 1'b1;
                        rd_m_addr = note_addr(slot2, 1'b0, ADDR_W'(mel_pos_next));
                        ctrl_next.per_m = 1'b1;
                    end
                end
                if (hb_inc >= len_h_eff)
                begin
                    if (har_pos_reg < lim_h)
                        har_pos_next = har_pos_reg + 1'b1;
                    har_wave_next = '0;
                    har_beat_next = '0;
                    if (chosen && har_pos_next < lim_h)
                    begin
                        rd_h_en = 1'b1;
                        rd_h_addr = note_addr(slot2, 1'b1, ADDR_W'(har_pos_next));
                        ctrl_next.per_h = 1'b1;
                    end
                end
            end
            OP_MEL_TICK:
            begin
                if (!ended_reg)
                begin
                    wave_rd_en = 1'b1;
                    wave_raddr = mel_wave_reg;
                    mel_wave_next = wave_step(mel_wave_reg);
                    ctrl_next.wave_m = 1'b1;
                end
            end
            OP_HAR_TICK:
            begin
                if (!ended_reg)
                begin
                    wave_rd_en = 1'b1;
                    wave_raddr = har_wave_reg;
                    har_wave_next = wave_step(har_wave_reg);
                    ctrl_next.wave_h = 1'b1;
                end
            end
            OP_LOAD_NOTE:
            begin
                if (int'(entry_index) < MAX_NOTES)
                    note_we = 1'b1;
            end
            OP_LOAD_WAVE:
            begin
                if (int'(wave_index) < WAVE_LENGTH)
                    wave_we = 1'b1;
            end
            OP_RESTART:
            begin
                ended_next    = 1'b0;
                mel_pos_next  = '0;
                har_pos_next  = '0;
                mel_beat_next = '0;
                har_beat_next = '0;
                mel_wave_next = '0;
                har_wave_next = '0;
                if (chosen)
                begin
                    rd_m_en = 1'b1;
                    rd_h_en = 1'b1;
                    ctrl_next.per_m = 1'b1;
                    ctrl_next.per_h = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        ctrl_next.ended = ended_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg    <= '0;
            s1_mel_reg <= S1_COUNT_RST;
            s1_har_reg <= S1_COUNT_RST;
            s2_mel_reg <= S2_COUNT_RST;
            s2_har_reg <= S2_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SONG_SELECT: sel_reg    <= cfg_data[SEL_W-1:0];
                CFG_S1_MELODY:   s1_mel_reg <= cfg_data;
                CFG_S1_HARMONY:  s1_har_reg <= cfg_data;
                CFG_S2_MELODY:   s2_mel_reg <= cfg_data;
                CFG_S2_HARMONY:  s2_har_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mel_pos_reg  <= '0;
            har_pos_reg  <= '0;
            mel_beat_reg <= '0;
            har_beat_reg <= '0;
            mel_wave_reg <= '0;
            har_wave_reg <= '0;
            ended_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mel_pos_reg  <= mel_pos_next;
                har_pos_reg  <= har_pos_next;
                mel_beat_reg <= mel_beat_next;
                har_beat_reg <= har_beat_next;
                mel_wave_reg <= mel_wave_next;
                har_wave_reg <= har_wave_next;
                ended_reg    <= ended_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // note lengths land when the read data leaves the second stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mel_len_reg <= '0;
            har_len_reg <= '0;
        end
        else if (s1_valid_reg && s1_take)
        begin
            if (ctrl_reg.per_m)
                mel_len_reg <= mel_q[NLEN_W-1:0];
            if (ctrl_reg.per_h)
                har_len_reg <= har_q[NLEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ctrl_reg <= ctrl_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && note_we)
            note_mem[note_waddr] <= {pitch_period, note_length};
        if (accept && rd_m_en)
            mel_q <= note_mem[rd_m_addr];
        if (accept && rd_h_en)
            har_q <= note_mem[rd_h_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && wave_we)
            wave_mem[wave_waddr] <= SAMPLE_BITS'(wave_value);
        if (accept && wave_rd_en)
            wave_q <= wave_mem[wave_raddr];
    end

    tvws_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .clk                  (clk),
        .rst_n                (rst_n),
        .s1_valid             (s1_valid_reg),
        .ctrl                 (ctrl_reg),
        .wave_q               (wave_q),
        .mel_period_q         (mel_q[WORD_W-1:NLEN_W]),
        .har_period_q         (har_q[WORD_W-1:NLEN_W]),
        .s1_take              (s1_take),
        .out_stall            (out_stall),
        .out_valid            (out_valid),
        .sample_valid         (sample_valid),
        .sample               (sample),
        .melody_period_valid  (melody_period_valid),
        .melody_period        (melody_period),
        .harmony_period_valid (harmony_period_valid),
        .harmony_period       (harmony_period),
        .song_ended           (song_ended)
    );

    `TVWS_ASSERT_IMP(a_stall_only_when_blocked, in_stall, out_valid && out_stall,
        "input stalled while output is free")
    `TVWS_ASSERT_IMP(a_sample_excludes_period, out_valid && sample_valid,
        !melody_period_valid && !harmony_period_valid, "sample and period in one result")
    `TVWS_ASSERT_IMP(a_sample_not_ended, out_valid && sample_valid, !song_ended,
        "sample produced after song end")
    `TVWS_ASSERT_NXT(a_accept_fills_stage, accept, s1_valid_reg,
        "accepted request lost before second stage")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import tvws_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
    localparam logic [SEL_W-1:0]    SEL_NONE   = 2'd0;
    localparam logic [SEL_W-1:0]    SEL_SPARE  = 2'd3;

    localparam int MELODY      = 0;
    localparam int HARMONY     = 1;
    localparam int NOTES       = MAX_NOTES_DEF;
    localparam int WAVES       = WAVE_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                slot;
        logic                vce;
        logic [EIDX_W-1:0]   idx;
        logic [PERIOD_W-1:0] period;
        logic [NLEN_W-1:0]   len;
        logic [WIDX_W-1:0]   widx;
        logic [WVAL_W-1:0]   wval;
    } seq_request_t;

    typedef struct packed {
        logic                smp_valid;
        logic [SAMPLE_W-1:0] smp;
        logic                mel_valid;
        logic [PERIOD_W-1:0] mel_per;
        logic                har_valid;
        logic [PERIOD_W-1:0] har_per;
        logic                done;
    } seq_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [OPCODE_W-1:0]   opcode;
    logic                  song_slot;
    logic                  voice;
    logic [EIDX_W-1:0]     entry_index;
    logic [PERIOD_W-1:0]   pitch_period;
    logic [NLEN_W-1:0]     note_length;
    logic [WIDX_W-1:0]     wave_index;
    logic [WVAL_W-1:0]     wave_value;
    logic                  out_valid;
    logic                  out_stall;
    logic                  sample_valid;
    logic [SAMPLE_W-1:0]   sample;
    logic                  melody_period_valid;
    logic [PERIOD_W-1:0]   melody_period;
    logic                  harmony_period_valid;
    logic [PERIOD_W-1:0]   harmony_period;
    logic                  song_ended;

    // sequencer mirror
    logic [PERIOD_W-1:0] note_pitch [4*NOTES];
    logic [NLEN_W-1:0]   note_beats [4*NOTES];
    bit                  note_loaded [4*NOTES];
    logic [WVAL_W-1:0]   wave_mem [WAVES];
    bit                  wave_loaded [WAVES];
    logic [7:0]          play_pos [2];
    logic [NLEN_W-1:0]   beat_cnt [2];
    logic [NLEN_W-1:0]   cur_len [2];
    logic [WIDX_W-1:0]   wave_pos [2];
    logic [SAMPLE_W-1:0] level [2];
    logic                song_done;
    logic [SEL_W-1:0]    sel_reg;
    logic [CNT_W-1:0]    count_reg [4];

    seq_result_t pending_results[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_cycles;
    bit hold_active;
    event hold_start;

    int cycle_count;
    int mismatches;
    int results_checked;
    int requests_sent;
    int reg_writes;
    int songs_ended;

    two_voice_wavetable_sequencer_core u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .opcode               (opcode),
        .song_slot            (song_slot),
        .voice                (voice),
        .entry_index          (entry_index),
        .pitch_period         (pitch_period),
        .note_length          (note_length),
        .wave_index           (wave_index),
        .wave_value           (wave_value),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .sample_valid         (sample_valid),
        .sample               (sample),
        .melody_period_valid  (melody_period_valid),
        .melody_period        (melody_period),
        .harmony_period_valid (harmony_period_valid),
        .harmony_period       (harmony_period),
        .song_ended           (song_ended)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit song_on();
        return sel_reg == SEL_SLOT1 || sel_reg == SEL_SLOT2;
    endfunction

    // counts above the table size clamp
    function automatic int voice_limit(int v);
        int c;
        if (!song_on())
            return NOTES;
        c = int'(count_reg[(int'(sel_reg) - 1) * 2 + v]);
        return (c > NOTES) ? NOTES : c;
    endfunction

    function automatic int note_addr(int v, int pos);
        return (int'(sel_reg) - 1) * 2 * NOTES + v * NOTES + pos;
    endfunction

    function automatic seq_result_t step_sequencer(seq_request_t r);
        seq_result_t res;
        int v;
        int lim;
        int a;
        res = '0;
        case (r.op)
            OP_BEAT:
            begin
                for (v = 0; v < 2; v++)
                    if (beat_cnt[v] != '1)
                        beat_cnt[v] = beat_cnt[v] + 1'b1;
                if (song_on() && (play_pos[MELODY] >= voice_limit(MELODY) ||
                                  play_pos[HARMONY] >= voice_limit(HARMONY)))
                begin
                    if (!song_done)
                        songs_ended++;
                    level[MELODY]  = '0;
                    level[HARMONY] = '0;
                    song_done      = 1'b1;
                end
                for (v = 0; v < 2; v++)
                begin
                    if (beat_cnt[v] >= cur_len[v])
                    begin
                        lim = voice_limit(v);
                        if (play_pos[v] < lim)
                            play_pos[v] = play_pos[v] + 1'b1;
                        wave_pos[v] = '0;
                        beat_cnt[v] = '0;
                        if (song_on() && play_pos[v] < lim)
                        begin
                            a = note_addr(v, int'(play_pos[v]));
                            cur_len[v] = note_beats[a];
                            if (v == MELODY)
                            begin
                                res.mel_valid = 1'b1;
                                res.mel_per   = note_pitch[a];
                            end
                            else
                            begin
                                res.har_valid = 1'b1;
                                res.har_per   = note_pitch[a];
                            end
                        end
                    end
                end
            end
            OP_MEL_TICK, OP_HAR_TICK:
            begin
                if (!song_done)
                begin
                    v = (r.op == OP_MEL_TICK) ? MELODY : HARMONY;
                    level[v]    = wave_mem[wave_pos[v]];
                    wave_pos[v] = wave_pos[v] + 1'b1;
                    res.smp_valid = 1'b1;
                    res.smp = SAMPLE_W'(({1'b0, level[MELODY]} + {1'b0, level[HARMONY]}) >> 1);
                end
            end
            OP_LOAD_NOTE:
            begin
                a = int'(r.slot) * 2 * NOTES + int'(r.vce) * NOTES + int'(r.idx);
                note_pitch[a]  = r.period;
                note_beats[a]  = r.len;
                note_loaded[a] = 1'b1;
            end
            OP_LOAD_WAVE:
            begin
                wave_mem[r.widx]    = r.wval;
                wave_loaded[r.widx] = 1'b1;
            end
            OP_RESTART:
            begin
                song_done = 1'b0;
                for (v = 0; v < 2; v++)
                begin
                    wave_pos[v] = '0;
                    play_pos[v] = '0;
                    beat_cnt[v] = '0;
                end
                if (song_on())
                begin
                    cur_len[MELODY]  = note_beats[note_addr(MELODY, 0)];
                    cur_len[HARMONY] = note_beats[note_addr(HARMONY, 0)];
                    res.mel_valid = 1'b1;
                    res.mel_per   = note_pitch[note_addr(MELODY, 0)];
                    res.har_valid = 1'b1;
                    res.har_per   = note_pitch[note_addr(HARMONY, 0)];
                end
            end
            default:
                ;
        endcase
        res.done = song_done;
        return res;
    endfunction

    // mostly short notes so songs actually move
    function automatic logic [NLEN_W-1:0] note_span();
        return ($urandom_range(24) == 0) ? NLEN_W'($urandom) : NLEN_W'($urandom_range(3));
    endfunction

    function automatic seq_request_t random_request(logic [OPCODE_W-1:0] op);
        seq_request_t r;
        r.op     = op;
        r.slot   = 1'($urandom);
        r.vce    = 1'($urandom);
        r.idx    = EIDX_W'($urandom);
        r.period = PERIOD_W'($urandom);
        r.len    = note_span();
        r.widx   = WIDX_W'($urandom);
        r.wval   = WVAL_W'($urandom);
        return r;
    endfunction

    function automatic seq_request_t compose(logic [OPCODE_W-1:0] op, logic slot, logic vce,
                                             logic [EIDX_W-1:0] idx, logic [PERIOD_W-1:0] period,
                                             logic [NLEN_W-1:0] len, logic [WIDX_W-1:0] widx,
                                             logic [WVAL_W-1:0] wval);
        return '{op, slot, vce, idx, period, len, widx, wval};
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(9))
            0: return '0;
            1: return 8'd1;
            2: return 8'd128;
            3: return 8'hFF;
            default: return CNT_W'($urandom_range(12, 2));
        endcase
    endfunction

    task automatic send_request(seq_request_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= r.op;
        song_slot    <= r.slot;
        voice        <= r.vce;
        entry_index  <= r.idx;
        pitch_period <= r.period;
        note_length  <= r.len;
        wave_index   <= r.widx;
        wave_value   <= r.wval;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(step_sequencer(r));
        requests_sent++;
    endtask

    // loads any note or wave entry the request is about to read, then sends it
    task automatic play(seq_request_t r);
        seq_request_t fill;
        int v;
        int a;
        int lim;
        int pos;
        case (r.op)
            OP_BEAT:
            begin
                for (v = 0; v < 2; v++)
                begin
                    lim = voice_limit(v);
                    pos = (play_pos[v] < lim) ? play_pos[v] + 1 : play_pos[v];
                    if (beat_cnt[v] + 1 >= cur_len[v] && song_on() && pos < lim)
                    begin
                        a = note_addr(v, pos);
                        if (!note_loaded[a])
                        begin
                            fill      = random_request(OP_LOAD_NOTE);
                            fill.slot = 1'(a / (2 * NOTES));
                            fill.vce  = 1'((a / NOTES) % 2);
                            fill.idx  = EIDX_W'(a % NOTES);
                            send_request(fill);
                        end
                    end
                end
            end
            OP_MEL_TICK, OP_HAR_TICK:
            begin
                v = (r.op == OP_MEL_TICK) ? MELODY : HARMONY;
                if (!song_done && !wave_loaded[wave_pos[v]])
                begin
                    fill      = random_request(OP_LOAD_WAVE);
                    fill.widx = wave_pos[v];
                    send_request(fill);
                end
            end
            OP_RESTART:
            begin
                if (song_on())
                    for (v = 0; v < 2; v++)
                        if (!note_loaded[note_addr(v, 0)])
                        begin
                            fill      = random_request(OP_LOAD_NOTE);
                            fill.slot = 1'(int'(sel_reg) - 1);
                            fill.vce  = 1'(v);
                            fill.idx  = '0;
                            send_request(fill);
                        end
            end
            default:
                ;
        endcase
        send_request(r);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SONG_SELECT)
            sel_reg = val[SEL_W-1:0];
        else
            count_reg[2'(idx - CFG_S1_MELODY)] = val;
        reg_writes++;
    endtask

    task automatic configure(logic [SEL_W-1:0] sel, logic [CNT_W-1:0] s1m, logic [CNT_W-1:0] s1h,
                             logic [CNT_W-1:0] s2m, logic [CNT_W-1:0] s2h);
        wait_drain();
        write_reg(CFG_SONG_SELECT, CFG_DATA_W'(sel));
        write_reg(CFG_S1_MELODY, s1m);
        write_reg(CFG_S1_HARMONY, s1h);
        write_reg(CFG_S2_MELODY, s2m);
        write_reg(CFG_S2_HARMONY, s2h);
    endtask

    task automatic test_directed();
        int n;
        configure(SEL_SLOT1, 8'd3, 8'd2, 8'd128, 8'd0);
        play(compose(OP_LOAD_WAVE, 1'b0, 1'b0, '0, '0, '0, 6'd0, 12'h000));
        play(compose(OP_LOAD_WAVE, 1'b0, 1'b0, '0, '0, '0, 6'd1, 12'hFFF));
        play(compose(OP_LOAD_WAVE, 1'b1, 1'b1, '1, '1, '1, 6'd63, 12'hFFF));
        play(compose(OP_LOAD_NOTE, 1'b0, 1'b0, 7'd0, 24'h000000, 16'd0, '0, '0));
        play(compose(OP_LOAD_NOTE, 1'b0, 1'b1, 7'd0, 24'hFFFFFF, 16'd1, '0, '0));
        play(compose(OP_LOAD_NOTE, 1'b1, 1'b1, 7'd127, 24'hFFFFFF, 16'hFFFF, '1, '1));
        play(compose(OP_SPARE_6, 1'b1, 1'b1, '1, '1, '1, '1, '1));
        play(compose(OP_SPARE_7, 1'b0, 1'b0, '0, '0, '0, '0, '0));
        play(random_request(OP_RESTART));
        // wave[0] = 0 and wave[1] = full scale, so the mix reaches both ends
        play(random_request(OP_MEL_TICK));
        play(random_request(OP_HAR_TICK));
        play(random_request(OP_MEL_TICK));
        play(random_request(OP_HAR_TICK));
        for (n = 0; n < 6; n++)
            play(random_request(OP_BEAT));
        // pitch tick after the end is silent
        play(random_request(OP_MEL_TICK));
        play(random_request(OP_RESTART));
        play(random_request(OP_HAR_TICK));
    endtask

    task automatic test_song_phase(int items, logic [SEL_W-1:0] sel, int beat_pct);
        int n;
        int k;
        logic [OPCODE_W-1:0] op;
        configure(sel, pick_count(), pick_count(), pick_count(), pick_count());
        play(random_request(OP_RESTART));
        for (n = 0; n < items; n++)
        begin
            k = $urandom_range(99);
            if (k < beat_pct)
                op = OP_BEAT;
            else
            begin
                k = $urandom_range(99);
                if (k < 30)
                    op = OP_MEL_TICK;
                else if (k < 60)
                    op = OP_HAR_TICK;
                else if (k < 78)
                    op = OP_LOAD_NOTE;
                else if (k < 90)
                    op = OP_LOAD_WAVE;
                else if (k < 97)
                    op = OP_RESTART;
                else
                    op = k[0] ? OP_SPARE_6 : OP_SPARE_7;
            end
            play(random_request(op));
        end
    endtask

    // zero-length first notes, then no song: positions run up to the table end
    task automatic test_no_song();
        configure(SEL_SLOT2, 8'hFF, 8'd128, 8'd4, 8'd0);
        play(compose(OP_LOAD_NOTE, 1'b1, 1'b0, 7'd0, 24'h5A5A5A, 16'd0, '0, '0));
        play(compose(OP_LOAD_NOTE, 1'b1, 1'b1, 7'd0, 24'hA5A5A5, 16'd0, '0, '0));
        play(random_request(OP_RESTART));
        play(random_request(OP_BEAT));
        play(random_request(OP_HAR_TICK));
        test_song_phase(140, SEL_NONE, 85);
        test_song_phase(30, SEL_SPARE, 50);
    endtask

    task automatic test_backpressure();
        int n;
        int saved;
        saved = tx_idle_pct;
        tx_idle_pct = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        hold_cycles = 80;
        -> hold_start;
        for (n = 0; n < 24; n++)
            play(random_request((n % 3 == 0) ? OP_BEAT : OP_MEL_TICK));
        tx_idle_pct = saved;
        // sender sits idle until every request has come back
        wait_drain();
    endtask

    always @(hold_start)
    begin
        hold_active = 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_active = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= hold_active || ($urandom_range(99) < rx_idle_pct);
    end

    task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: %s expected %0h, got %0h", cycle_count, field, want, got);
    endtask

    always @(posedge clk)
    begin
        seq_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("cycle %0d: result with no request outstanding", cycle_count);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (sample_valid !== want.smp_valid)
                    flag_mismatch("sample_valid", 32'(want.smp_valid), 32'(sample_valid));
                if (sample !== want.smp)
                    flag_mismatch("sample", 32'(want.smp), 32'(sample));
                if (melody_period_valid !== want.mel_valid)
                    flag_mismatch("melody_period_valid", 32'(want.mel_valid),
                                  32'(melody_period_valid));
                if (melody_period !== want.mel_per)
                    flag_mismatch("melody_period", 32'(want.mel_per), 32'(melody_period));
                if (harmony_period_valid !== want.har_valid)
                    flag_mismatch("harmony_period_valid", 32'(want.har_valid),
                                  32'(harmony_period_valid));
                if (harmony_period !== want.har_per)
                    flag_mismatch("harmony_period", 32'(want.har_per), 32'(harmony_period));
                if (song_ended !== want.done)
                    flag_mismatch("song_ended", 32'(want.done), 32'(song_ended));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d requests outstanding",
                     cycle_count, pending_results.size());
            $display("two_voice_wavetable_sequencer_core verification failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        opcode       = OP_BEAT;
        song_slot    = 1'b0;
        voice        = 1'b0;
        entry_index  = '0;
        pitch_period = '0;
        note_length  = '0;
        wave_index   = '0;
        wave_value   = '0;
        out_stall    = 1'b0;
        hold_active  = 1'b0;
        hold_cycles  = 0;
        for (n = 0; n < 2; n++)
        begin
            play_pos[n] = '0;
            beat_cnt[n] = '0;
            cur_len[n]  = '0;
            wave_pos[n] = '0;
            level[n]    = '0;
        end
        song_done    = 1'b0;
        sel_reg      = SEL_NONE;
        count_reg[0] = S1_COUNT_RST;
        count_reg[1] = S1_COUNT_RST;
        count_reg[2] = S2_COUNT_RST;
        count_reg[3] = S2_COUNT_RST;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 27;
        rx_idle_pct = 68;
        test_directed();
        test_song_phase(60, SEL_SLOT1, 40);
        test_backpressure();

        tx_idle_pct = 68;
        rx_idle_pct = 27;
        test_song_phase(60, SEL_SLOT2, 40);
        test_no_song();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_song_phase(60, SEL_SLOT1, 45);
        test_song_phase(60, SEL_SLOT2, 45);

        wait_drain();
        repeat (10) @(posedge clk);
        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 requests_sent, results_checked, mismatches);
        $display("%0d register writes across all song selects, %0d song ends seen",
                 reg_writes, songs_ended);
        if (mismatches == 0)
            $display("two_voice_wavetable_sequencer_core verification clean");
        else
            $display("two_voice_wavetable_sequencer_core verification failed");
        $finish;
    end

endmodule
